// File: hdl/pu_pkg.sv
// package: types, constants and tables for the permutation unranker
`timescale 1ns / 1ps

package pu_pkg;

    localparam int NUM_SYMBOLS = 10;
    localparam int RANK_W      = 22;
    localparam int DIGIT_W     = 4;
    localparam int IDX_W       = $clog2(NUM_SYMBOLS);
    localparam int STEP_W      = $clog2(NUM_SYMBOLS + 1);
    localparam int MULT_W      = 32;
    localparam int UPC_W       = 3;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_QUOT,
        OP_EMIT,
        OP_ERR
    } uop_t;

    typedef enum logic [2:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NO_START,
        JC_RANGE_ERR,
        JC_MORE
    } jcond_t;

    localparam logic [UPC_W-1:0] UA_IDLE  = UPC_W'(0);
    localparam logic [UPC_W-1:0] UA_CHECK = UPC_W'(1);
    localparam logic [UPC_W-1:0] UA_QUOT  = UPC_W'(2);
    localparam logic [UPC_W-1:0] UA_EMIT  = UPC_W'(3);
    localparam logic [UPC_W-1:0] UA_END   = UPC_W'(4);
    localparam logic [UPC_W-1:0] UA_ERR   = UPC_W'(5);

    typedef struct packed {
        uop_t             op;
        jcond_t           cond;
        logic [UPC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic start;
        logic range_err;
        logic more;
    } dp_status_t;

    typedef logic [NUM_SYMBOLS-1:0][NUM_SYMBOLS-1:0][MULT_W-1:0] mult_tab_t;

    function automatic longint fact_of(int k);
        longint f;
        f = 1;
        for (int i = 2; i <= k; i++)
            f = f * longint'(i);
        return f;
    endfunction

    // row s holds q * (NUM_SYMBOLS-1-s)! for q = 0 .. NUM_SYMBOLS-1
    function automatic mult_tab_t build_mult_tab();
        mult_tab_t t;
        longint    f;
        for (int s = 0; s < NUM_SYMBOLS; s++)
        begin
            f = fact_of(NUM_SYMBOLS - 1 - s);
            for (int q = 0; q < NUM_SYMBOLS; q++)
                t[s][q] = MULT_W'(longint'(q) * f);
        end
        return t;
    endfunction

    localparam mult_tab_t   MULT_TAB   = build_mult_tab();
    localparam logic [63:0] FACT_TOTAL = 64'(fact_of(NUM_SYMBOLS));

endpackage

// File: hdl/pu_microcode_rom.sv
// microcode store: one control word per sequencer address
`timescale 1ns / 1ps

module pu_microcode_rom
    import pu_pkg::*;
(
    input  logic [UPC_W-1:0] upc,
    output ctrl_word_t       cw
);

    always_comb
    begin
        unique case (upc)
            UA_IDLE:  cw = '{op: OP_ACCEPT, cond: JC_NO_START,  target: UA_IDLE};
            UA_CHECK: cw = '{op: OP_NOP,    cond: JC_RANGE_ERR, target: UA_ERR};
            UA_QUOT:  cw = '{op: OP_QUOT,   cond: JC_NEVER,     target: UA_IDLE};
            UA_EMIT:  cw = '{op: OP_EMIT,   cond: JC_MORE,      target: UA_QUOT};
            UA_END:   cw = '{op: OP_NOP,    cond: JC_ALWAYS,    target: UA_IDLE};
            UA_ERR:   cw = '{op: OP_ERR,    cond: JC_ALWAYS,    target: UA_IDLE};
            default:  cw = '{op: OP_NOP,    cond: JC_ALWAYS,    target: UA_IDLE};
        endcase
    end

endmodule

// File: hdl/pu_sequencer.sv
// micro program counter with conditional jumps
`timescale 1ns / 1ps

module pu_sequencer
    import pu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_word_t       cw,
    input  dp_status_t       status,
    output logic [UPC_W-1:0] upc,
    output logic             busy
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             take;

    always_comb
    begin
        unique case (cw.cond)
            JC_NEVER:     take = 1'b0;
            JC_ALWAYS:    take = 1'b1;
            JC_NO_START:  take = !status.start;
            JC_RANGE_ERR: take = status.range_err;
            JC_MORE:      take = status.more;
            default:      take = 1'b1;
        endcase
        upc_next = take ? cw.target : UPC_W'(upc_reg + UPC_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= UA_IDLE;
        else
            upc_reg <= upc_next;
    end

    assign upc  = upc_reg;
    assign busy = (upc_reg != UA_IDLE);

    a_upc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= UA_ERR)
        else $error("micro pc left the program");

    a_start_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UA_IDLE && status.start) |=> (upc_reg == UA_CHECK))
        else $error("accepted word did not start the program");

endmodule

// File: hdl/pu_datapath.sv
// rank register, unused digit list and quotient selection
`timescale 1ns / 1ps

module pu_datapath
    import pu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctrl_word_t         cw,
    input  logic               start,
    input  logic [RANK_W-1:0]  rank,
    output dp_status_t         status,
    output logic [DIGIT_W-1:0] digit,
    output logic               last_digit,
    output logic               rank_error,
    output logic               strobe
);

    logic [RANK_W-1:0]                  rem_reg, rem_next;
    logic [NUM_SYMBOLS-1:0][DIGIT_W-1:0] list_reg, list_next;
    logic [STEP_W-1:0]                  step_reg, step_next;
    logic                               err_reg, err_next;
    logic [IDX_W-1:0]                   pos_reg, pos_next;
    logic [RANK_W-1:0]                  mult_reg, mult_next;
    logic [DIGIT_W-1:0]                 digit_reg, digit_next;
    logic                               last_reg, last_next;
    logic                               rerr_reg, rerr_next;
    logic                               strobe_reg, strobe_next;

    logic                               rank_bad;
    logic [STEP_W-1:0]                  count;
    logic [IDX_W-1:0]                   pos_calc;
    logic [IDX_W-1:0]                   row;
    logic [MULT_W-1:0]                  rem_wide;
    logic                               at_last;

    assign row      = step_reg[IDX_W-1:0];
    assign count    = STEP_W'(NUM_SYMBOLS) - step_reg;
    assign rem_wide = MULT_W'(rem_reg);
    assign at_last  = (step_reg == STEP_W'(NUM_SYMBOLS - 1));
    assign rank_bad = (rank == '0) || (64'(rank) > FACT_TOTAL);

    // quotient as count of multiples not above the rank, capped by the list length
    always_comb
    begin
        pos_calc = '0;
        for (int q = 1; q < NUM_SYMBOLS; q++)
            pos_calc = pos_calc + IDX_W'((STEP_W'(q) < count) &&
                                         (rem_wide >= MULT_TAB[row][q]));
    end

    always_comb
    begin
        rem_next    = rem_reg;
        list_next   = list_reg;
        step_next   = step_reg;
        err_next    = err_reg;
        pos_next    = pos_reg;
        mult_next   = mult_reg;
        digit_next  = digit_reg;
        last_next   = last_reg;
        rerr_next   = rerr_reg;
        strobe_next = 1'b0;
        unique case (cw.op)
            OP_NOP:
            begin
            end
            OP_ACCEPT:
            begin
                if (start)
                begin
                    err_next = rank_bad;
                    if (!rank_bad)
                    begin
                        rem_next  = RANK_W'(rank - RANK_W'(1));
                        step_next = '0;
                        for (int j = 0; j < NUM_SYMBOLS; j++)
                            list_next[j] = DIGIT_W'(j);
                    end
                end
            end
            OP_QUOT:
            begin
                pos_next  = pos_calc;
                mult_next = RANK_W'(MULT_TAB[row][pos_calc]);
            end
            OP_EMIT:
            begin
                rem_next    = rem_reg - mult_reg;
                digit_next  = list_reg[pos_reg];
                last_next   = at_last;
                rerr_next   = 1'b0;
                strobe_next = 1'b1;
                step_next   = step_reg + STEP_W'(1);
                // close the gap left by the taken digit
                for (int j = 0; j < NUM_SYMBOLS - 1; j++)
                    if (IDX_W'(j) >= pos_reg)
                        list_next[j] = list_reg[j+1];
            end
            OP_ERR:
            begin
                digit_next  = '0;
                last_next   = 1'b1;
                rerr_next   = 1'b1;
                strobe_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= '0;
            err_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            err_reg    <= err_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        list_reg  <= list_next;
        pos_reg   <= pos_next;
        mult_reg  <= mult_next;
        digit_reg <= digit_next;
        last_reg  <= last_next;
        rerr_reg  <= rerr_next;
    end

    assign status.start     = start;
    assign status.range_err = err_reg;
    assign status.more      = !at_last;

    assign digit      = digit_reg;
    assign last_digit = last_reg;
    assign rank_error = rerr_reg;
    assign strobe     = strobe_reg;

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == OP_EMIT) |-> (step_reg < STEP_W'(NUM_SYMBOLS) &&
                                STEP_W'(pos_reg) < count))
        else $error("digit taken beyond the unused list");

    a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && rerr_reg) |-> (last_reg && digit_reg == '0))
        else $error("error word must be a single last word with digit zero");

endmodule

// File: hdl/permutation_unrank.sv
// top level: lexicographic permutation unranker, one digit word per strobe
// a valid rank gives NUM_SYMBOLS words, the first strobed from the emit step after the check
// and quotient steps, then one per quotient and emit pair; busy drops after the last word
// a rank of zero or above NUM_SYMBOLS! gives one error word, strobed by the error step after check
// pace is set by the two micro steps per digit: quotient select, then emit and compact
// reset returns the micro pc to idle and clears the strobe; the digit list reloads per rank
`timescale 1ns / 1ps

module permutation_unrank
    import pu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [RANK_W-1:0]  rank,
    output logic [DIGIT_W-1:0] digit,
    output logic               last_digit,
    output logic               rank_error,
    output logic               strobe
);

    logic [UPC_W-1:0] upc;
    ctrl_word_t       cw;
    dp_status_t       status;
    logic             seq_busy;

    pu_microcode_rom u_rom (
        .upc (upc),
        .cw  (cw)
    );

    pu_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cw     (cw),
        .status (status),
        .upc    (upc),
        .busy   (seq_busy)
    );

    pu_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cw         (cw),
        .start      (start),
        .rank       (rank),
        .status     (status),
        .digit      (digit),
        .last_digit (last_digit),
        .rank_error (rank_error),
        .strobe     (strobe)
    );

    assign busy = seq_busy;

endmodule

// File: tb/sv/permutation_unrank_tb.sv
// testbench: directed and random ranks checked word by word against tabulated permutations or a digit-list predictor
`timescale 1ns / 1ps

module permutation_unrank_tb;

    import pu_pkg::*;

    localparam int N_DIR       = 17;
    localparam int RAND_ITEMS  = 320;
    localparam int CALM_ITEMS  = 60;
    localparam int QUIET_LIMIT = 500;
    localparam int DRAIN_WAIT  = 30;
    localparam int PERM_W      = NUM_SYMBOLS * DIGIT_W;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic               err;
    } digit_word_t;

    typedef struct packed {
        logic [RANK_W-1:0] value;
        logic              typed;
        logic              bad;
        logic [PERM_W-1:0] perm;
    } rank_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [RANK_W-1:0]  rank = '0;
    logic               busy;
    logic [DIGIT_W-1:0] digit;
    logic               last_digit;
    logic               rank_error;
    logic               strobe;

    logic               row_typed = 1'b0;
    logic               row_bad = 1'b0;
    logic [PERM_W-1:0]  row_perm = '0;

    digit_word_t        digits_due [$];
    int                 mismatches = 0;
    int                 quiet_cycles = 0;

    rank_row_t dir_rows [N_DIR] = '{
        '{22'd1,       1'b1, 1'b0, 40'h0123456789},
        '{22'd2,       1'b1, 1'b0, 40'h0123456798},
        '{22'd0,       1'b1, 1'b1, 40'h0},
        '{22'd3628800, 1'b1, 1'b0, 40'h9876543210},
        '{22'd3628799, 1'b1, 1'b0, 40'h9876543201},
        '{22'd3628801, 1'b1, 1'b1, 40'h0},
        '{22'h3FFFFF,  1'b1, 1'b1, 40'h0},
        '{22'd362880,  1'b0, 1'b0, 40'h0},
        '{22'd362881,  1'b0, 1'b0, 40'h0},
        '{22'd1814400, 1'b0, 1'b0, 40'h0},
        '{22'd1814401, 1'b0, 1'b0, 40'h0},
        '{22'h2AAAAA,  1'b0, 1'b0, 40'h0},
        '{22'h155555,  1'b0, 1'b0, 40'h0},
        '{22'h200000,  1'b0, 1'b0, 40'h0},
        '{22'h3FFFFE,  1'b1, 1'b1, 40'h0},
        '{22'd3,       1'b0, 1'b0, 40'h0},
        '{22'd1,       1'b1, 1'b0, 40'h0123456789}
    };

    permutation_unrank dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .rank       (rank),
        .digit      (digit),
        .last_digit (last_digit),
        .rank_error (rank_error),
        .strobe     (strobe)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void push_typed(input logic [PERM_W-1:0] perm, input logic bad);
        digit_word_t w;
        if (bad)
        begin
            w = '{digit: '0, last: 1'b1, err: 1'b1};
            digits_due.push_back(w);
            return;
        end
        for (int i = 0; i < NUM_SYMBOLS; i++)
        begin
            w.digit = perm[(NUM_SYMBOLS - 1 - i) * DIGIT_W +: DIGIT_W];
            w.last  = (i == NUM_SYMBOLS - 1);
            w.err   = 1'b0;
            digits_due.push_back(w);
        end
    endfunction

    function automatic void push_permutation(input logic [RANK_W-1:0] r);
        logic [DIGIT_W-1:0] pool [NUM_SYMBOLS];
        longint             weight [NUM_SYMBOLS + 1];
        longint             left;
        longint             q;
        int                 cnt;
        digit_word_t        w;
        weight[0] = 1;
        for (int k = 1; k <= NUM_SYMBOLS; k++)
            weight[k] = weight[k - 1] * longint'(k);
        if (r == '0 || longint'(r) > weight[NUM_SYMBOLS])
        begin
            push_typed('0, 1'b1);
            return;
        end
        for (int i = 0; i < NUM_SYMBOLS; i++)
            pool[i] = DIGIT_W'(i);
        left = longint'(r) - 1;
        cnt  = NUM_SYMBOLS;
        for (int k = NUM_SYMBOLS; k > 0; k--)
        begin
            q = left / weight[k - 1];
            if (q >= cnt)
                q = cnt - 1;
            left    = left % weight[k - 1];
            w.digit = pool[q];
            w.last  = (k == 1);
            w.err   = 1'b0;
            digits_due.push_back(w);
            for (int j = int'(q); j + 1 < cnt; j++)
                pool[j] = pool[j + 1];
            cnt--;
        end
    endfunction

    // check strobed words first, then queue what the accepted rank should give
    always @(posedge clk)
    begin : word_check
        digit_word_t want;
        if (rst_n && strobe)
        begin
            if (digits_due.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, got digit %0d last %0b err %0b",
                         $time, digit, last_digit, rank_error);
                mismatches++;
            end
            else
            begin
                want = digits_due.pop_front();
                if (digit !== want.digit)
                begin
                    $display("%0t: digit expected %0d, got %0d", $time, want.digit, digit);
                    mismatches++;
                end
                if (last_digit !== want.last)
                begin
                    $display("%0t: last_digit expected %0b, got %0b",
                             $time, want.last, last_digit);
                    mismatches++;
                end
                if (rank_error !== want.err)
                begin
                    $display("%0t: rank_error expected %0b, got %0b",
                             $time, want.err, rank_error);
                    mismatches++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            if (row_typed)
                push_typed(row_perm, row_bad);
            else
                push_permutation(rank);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || strobe || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("permutation_unrank_tb: done, errors");
            $finish;
        end
    end

    task automatic issue_rank(input logic [RANK_W-1:0] r, input logic typed, input logic bad,
                              input logic [PERM_W-1:0] perm, input bit may_idle);
        int gap;
        if (may_idle && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        rank      <= r;
        row_typed <= typed;
        row_bad   <= bad;
        row_perm  <= perm;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [RANK_W-1:0] random_rank();
        case ($urandom_range(0, 9))
            0:
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return RANK_W'($urandom_range(3628801, 4194303));
                    default: return RANK_W'($urandom);
                endcase
            1:       return RANK_W'($urandom_range(1, 100));
            2:       return RANK_W'($urandom_range(3628700, 3628800));
            default: return RANK_W'($urandom_range(1, 3628800));
        endcase
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIR; i++)
            issue_rank(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].bad,
                       dir_rows[i].perm, 1'b1);
        for (int i = 0; i < RAND_ITEMS; i++)
            issue_rank(random_rank(), 1'b0, 1'b0, '0, i < RAND_ITEMS - CALM_ITEMS);
        start <= 1'b0;
        while (digits_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("permutation_unrank_tb: done, clean");
        else
            $display("permutation_unrank_tb: done, errors");
        $finish;
    end

endmodule

// File: files.f
hdl/pu_pkg.sv
hdl/pu_microcode_rom.sv
hdl/pu_sequencer.sv
hdl/pu_datapath.sv
hdl/permutation_unrank.sv
tb/sv/permutation_unrank_tb.sv
